### hdl/sab_pkg.sv
// Shared types and codes for the suffix array builder.
// Depends on nothing; used by the controller, datapath and top level.
package sab_pkg;

    // Input word: one load or one read request
    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       last;
        logic [9:0] position;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [9:0]  suffix_start;
        logic [10:0] text_length;
        logic [1:0]  status;
    } out_word_t;

    localparam logic       ACT_LOAD = 1'b0;
    localparam logic       ACT_READ = 1'b1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_RANGE     = 2'd2;
    localparam logic [1:0] STAT_NOT_BUILT = 2'd3;

    // Datapath operations, one per cycle
    typedef enum logic [5:0] {
        OP_IDLE, OP_RD_OUT, OP_CLR,
        OP_CNT_RT, OP_CNT_RB, OP_CNT_WB,
        OP_PFX_R, OP_PFX_W,
        OP_RNK_RT, OP_RNK_RB, OP_RNK_W,
        OP_PLC_RT, OP_PLC_RB, OP_PLC_W,
        OP_NOP, OP_PASS_START, OP_PASS_R0, OP_PASS_R0W,
        OP_SCAN_RS, OP_SCAN_RR, OP_SCAN_CMP,
        OP_KEY_INIT, OP_KEY_RS, OP_KEY_RR, OP_KEY_W,
        OP_INS_INIT, OP_INS_RV, OP_INS_LV, OP_INS_RP, OP_INS_CMP, OP_INS_PUT,
        OP_BASE_RS, OP_BASE_RR, OP_BASE_W,
        OP_ASN_R, OP_ASN_W,
        OP_RUN_END, OP_PASS_END, OP_DONE
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    // Status flags from datapath to controller
    typedef struct packed {
        logic go_build;
        logic go_read;
        logic i_eq_n;
        logic i_last;
        logic b_last;
        logic rank_eq;
        logic run_long;
        logic j_eq_e;
        logic j_gt_s;
        logic key_gt;
        logic ii_done;
        logic off_lt_n;
    } dp_stat_t;

endpackage

### hdl/sab_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/sab_ctrl.sv
// Build sequencer for the suffix array builder.
// Depends on sab_pkg; drives the datapath with one operation per cycle.
module sab_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  sab_pkg::dp_stat_t stat,
    output sab_pkg::cmd_t     cmd
);

    typedef enum logic [5:0] {
        S_IDLE, S_RD_OUT, S_CLR,
        S_CNT_RT, S_CNT_RB, S_CNT_WB,
        S_PFX_R, S_PFX_W,
        S_RNK_RT, S_RNK_RB, S_RNK_W,
        S_PLC_RT, S_PLC_RB, S_PLC_W,
        S_PASS_CHK, S_PASS_START, S_PASS_R0, S_PASS_R0W,
        S_SCAN_TEST, S_SCAN_RS, S_SCAN_RR, S_SCAN_CMP, S_FIN,
        S_KEY_INIT, S_KEY_RS, S_KEY_RR, S_KEY_W,
        S_INS_INIT, S_INS_RV, S_INS_LV, S_INS_TEST, S_INS_RP, S_INS_CMP,
        S_INS_PUT, S_INS_NEXT,
        S_BASE_RS, S_BASE_RR, S_BASE_W,
        S_ASN_R, S_ASN_W,
        S_RUN_END, S_PASS_END, S_DONE
    } state_t;

    state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (stat.go_build) state_next = S_CLR;
                else if (stat.go_read) state_next = S_RD_OUT;
            end
            S_RD_OUT:     state_next = S_IDLE;
            S_CLR:        if (stat.b_last) state_next = S_CNT_RT;
            S_CNT_RT:     state_next = S_CNT_RB;
            S_CNT_RB:     state_next = S_CNT_WB;
            S_CNT_WB:     state_next = stat.i_last ? S_PFX_R : S_CNT_RT;
            S_PFX_R:      state_next = S_PFX_W;
            S_PFX_W:      state_next = stat.b_last ? S_RNK_RT : S_PFX_R;
            S_RNK_RT:     state_next = S_RNK_RB;
            S_RNK_RB:     state_next = S_RNK_W;
            S_RNK_W:      state_next = stat.i_last ? S_PLC_RT : S_RNK_RT;
            S_PLC_RT:     state_next = S_PLC_RB;
            S_PLC_RB:     state_next = S_PLC_W;
            S_PLC_W:      state_next = stat.i_last ? S_PASS_CHK : S_PLC_RT;
            S_PASS_CHK:   state_next = stat.off_lt_n ? S_PASS_START : S_DONE;
            S_PASS_START: state_next = S_PASS_R0;
            S_PASS_R0:    state_next = S_PASS_R0W;
            S_PASS_R0W:   state_next = S_SCAN_TEST;
            S_SCAN_TEST:  state_next = stat.i_eq_n ? S_FIN : S_SCAN_RS;
            S_SCAN_RS:    state_next = S_SCAN_RR;
            S_SCAN_RR:    state_next = S_SCAN_CMP;
            S_SCAN_CMP:   state_next = stat.rank_eq ? S_SCAN_TEST : S_FIN;
            S_FIN:        state_next = stat.run_long ? S_KEY_INIT : S_RUN_END;
            S_KEY_INIT:   state_next = S_KEY_RS;
            S_KEY_RS:     state_next = S_KEY_RR;
            S_KEY_RR:     state_next = S_KEY_W;
            S_KEY_W:      state_next = stat.j_eq_e ? S_INS_INIT : S_KEY_RS;
            S_INS_INIT:   state_next = S_INS_RV;
            S_INS_RV:     state_next = S_INS_LV;
            S_INS_LV:     state_next = S_INS_TEST;
            S_INS_TEST:   state_next = stat.j_gt_s ? S_INS_RP : S_INS_PUT;
            S_INS_RP:     state_next = S_INS_CMP;
            S_INS_CMP:    state_next = stat.key_gt ? S_INS_TEST : S_INS_NEXT;
            S_INS_PUT:    state_next = S_INS_NEXT;
            S_INS_NEXT:   state_next = stat.ii_done ? S_BASE_RS : S_INS_RV;
            S_BASE_RS:    state_next = S_BASE_RR;
            S_BASE_RR:    state_next = S_BASE_W;
            S_BASE_W:     state_next = S_ASN_R;
            S_ASN_R:      state_next = S_ASN_W;
            S_ASN_W:      state_next = stat.j_eq_e ? S_RUN_END : S_ASN_R;
            S_RUN_END:    state_next = stat.i_eq_n ? S_PASS_END : S_SCAN_TEST;
            S_PASS_END:   state_next = S_PASS_CHK;
            S_DONE:       state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Operation for the current state
    always_comb begin
        case (state_reg)
            S_IDLE:       cmd.op = sab_pkg::OP_IDLE;
            S_RD_OUT:     cmd.op = sab_pkg::OP_RD_OUT;
            S_CLR:        cmd.op = sab_pkg::OP_CLR;
            S_CNT_RT:     cmd.op = sab_pkg::OP_CNT_RT;
            S_CNT_RB:     cmd.op = sab_pkg::OP_CNT_RB;
            S_CNT_WB:     cmd.op = sab_pkg::OP_CNT_WB;
            S_PFX_R:      cmd.op = sab_pkg::OP_PFX_R;
            S_PFX_W:      cmd.op = sab_pkg::OP_PFX_W;
            S_RNK_RT:     cmd.op = sab_pkg::OP_RNK_RT;
            S_RNK_RB:     cmd.op = sab_pkg::OP_RNK_RB;
            S_RNK_W:      cmd.op = sab_pkg::OP_RNK_W;
            S_PLC_RT:     cmd.op = sab_pkg::OP_PLC_RT;
            S_PLC_RB:     cmd.op = sab_pkg::OP_PLC_RB;
            S_PLC_W:      cmd.op = sab_pkg::OP_PLC_W;
            S_PASS_START: cmd.op = sab_pkg::OP_PASS_START;
            S_PASS_R0:    cmd.op = sab_pkg::OP_PASS_R0;
            S_PASS_R0W:   cmd.op = sab_pkg::OP_PASS_R0W;
            S_SCAN_RS:    cmd.op = sab_pkg::OP_SCAN_RS;
            S_SCAN_RR:    cmd.op = sab_pkg::OP_SCAN_RR;
            S_SCAN_CMP:   cmd.op = sab_pkg::OP_SCAN_CMP;
            S_KEY_INIT:   cmd.op = sab_pkg::OP_KEY_INIT;
            S_KEY_RS:     cmd.op = sab_pkg::OP_KEY_RS;
            S_KEY_RR:     cmd.op = sab_pkg::OP_KEY_RR;
            S_KEY_W:      cmd.op = sab_pkg::OP_KEY_W;
            S_INS_INIT:   cmd.op = sab_pkg::OP_INS_INIT;
            S_INS_RV:     cmd.op = sab_pkg::OP_INS_RV;
            S_INS_LV:     cmd.op = sab_pkg::OP_INS_LV;
            S_INS_RP:     cmd.op = sab_pkg::OP_INS_RP;
            S_INS_CMP:    cmd.op = sab_pkg::OP_INS_CMP;
            S_INS_PUT:    cmd.op = sab_pkg::OP_INS_PUT;
            S_BASE_RS:    cmd.op = sab_pkg::OP_BASE_RS;
            S_BASE_RR:    cmd.op = sab_pkg::OP_BASE_RR;
            S_BASE_W:     cmd.op = sab_pkg::OP_BASE_W;
            S_ASN_R:      cmd.op = sab_pkg::OP_ASN_R;
            S_ASN_W:      cmd.op = sab_pkg::OP_ASN_W;
            S_RUN_END:    cmd.op = sab_pkg::OP_RUN_END;
            S_PASS_END:   cmd.op = sab_pkg::OP_PASS_END;
            S_DONE:       cmd.op = sab_pkg::OP_DONE;
            default:      cmd.op = sab_pkg::OP_NOP;
        endcase
    end

endmodule

### hdl/sab_datapath.sv
// Datapath of the suffix array builder: stores, counters, output word.
// Depends on sab_pkg and sab_ram; sequenced by sab_ctrl.
module sab_datapath #(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sab_pkg::cmd_t       cmd,
    output sab_pkg::dp_stat_t   stat,
    input  logic                s_valid,
    output logic                s_ready,
    input  sab_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sab_pkg::out_word_t  m_data
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int OW = CW + 1;
    localparam int BW = $clog2(ALPHABET);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic          built_reg, built_next;
    logic [CW-1:0] i_reg, i_next;
    logic [AW-1:0] s_reg, s_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] ii_reg, ii_next;
    logic [OW-1:0] off_reg, off_next;
    logic [CW-1:0] sum_reg, sum_next;
    logic [BW-1:0] b_reg, b_next;
    logic [BW-1:0] bidx_reg, bidx_next;
    logic [AW-1:0] rs_reg, rs_next;
    logic [AW-1:0] nrank_reg, nrank_next;
    logic [AW-1:0] v_reg, v_next;
    logic [CW-1:0] kv_reg, kv_next;
    logic [CW-1:0] prev_reg, prev_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] r_reg, r_next;
    logic          inrng_reg, inrng_next;
    logic          m_valid_reg, m_valid_next;
    sab_pkg::out_word_t m_word_reg, m_word_next;

    // Memory ports
    logic          txt_we;
    logic [AW-1:0] txt_wa, txt_ra;
    logic [7:0]    txt_wd, txt_rd;
    logic          bkt_we;
    logic [BW-1:0] bkt_wa, bkt_ra;
    logic [CW-1:0] bkt_wd, bkt_rd;
    logic          sa_we;
    logic [AW-1:0] sa_wa, sa_ra, sa_wd, sa_rd;
    logic          rk_we;
    logic [AW-1:0] rk_wa, rk_ra, rk_wd, rk_rd;
    logic          key_we;
    logic [AW-1:0] key_wa, key_ra;
    logic [CW-1:0] key_wd, key_rd;

    sab_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text (
        .aclk(aclk), .wr_en(txt_we), .wr_addr(txt_wa), .wr_data(txt_wd),
        .rd_addr(txt_ra), .rd_data(txt_rd));
    sab_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_bucket (
        .aclk(aclk), .wr_en(bkt_we), .wr_addr(bkt_wa), .wr_data(bkt_wd),
        .rd_addr(bkt_ra), .rd_data(bkt_rd));
    sab_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_sorted (
        .aclk(aclk), .wr_en(sa_we), .wr_addr(sa_wa), .wr_data(sa_wd),
        .rd_addr(sa_ra), .rd_data(sa_rd));
    sab_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_rank (
        .aclk(aclk), .wr_en(rk_we), .wr_addr(rk_wa), .wr_data(rk_wd),
        .rd_addr(rk_ra), .rd_data(rk_rd));
    sab_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_key (
        .aclk(aclk), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
        .rd_addr(key_ra), .rd_data(key_rd));

    // Input handshake: a load without last needs no output slot
    logic          idle;
    logic          out_free;
    logic          acc;
    logic          is_load;
    logic          pos_ok;
    logic [CW-1:0] eff_cnt;
    logic [BW-1:0] bk;
    logic [OW-1:0] shift_pos;
    logic [CW-1:0] i_plus1;
    logic [CW-1:0] j_plus1;

    assign idle     = (cmd.op == sab_pkg::OP_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign is_load  = (s_data.action == sab_pkg::ACT_LOAD);
    assign s_ready  = idle && (out_free || (is_load && !s_data.last));
    assign acc      = s_valid && s_ready;
    assign pos_ok   = 32'(s_data.position) < 32'(cnt_reg);
    assign eff_cnt  = built_reg ? '0 : cnt_reg;

    // Byte to bucket, saturating at the top of the alphabet
    assign bk = (9'(txt_rd) >= 9'(ALPHABET)) ? BW'(ALPHABET - 1) : BW'(txt_rd);

    assign shift_pos = OW'(sa_rd) + off_reg;
    assign i_plus1   = CW'(i_reg + 1'b1);
    assign j_plus1   = CW'(j_reg + 1'b1);

    // Status to controller
    always_comb begin
        stat.go_build = acc && is_load && s_data.last;
        stat.go_read  = acc && !is_load && built_reg && pos_ok;
        stat.i_eq_n   = (i_reg == cnt_reg);
        stat.i_last   = (i_plus1 == cnt_reg);
        stat.b_last   = (b_reg == BW'(ALPHABET - 1));
        stat.rank_eq  = (rk_rd == rs_reg);
        stat.run_long = (i_reg > CW'(CW'(s_reg) + 1'b1));
        stat.j_eq_e   = (j_plus1 == i_reg);
        stat.j_gt_s   = (j_reg > CW'(s_reg));
        stat.key_gt   = (key_rd > kv_reg);
        stat.ii_done  = (ii_reg == i_reg);
        stat.off_lt_n = (off_reg < OW'(cnt_reg));
    end

    // Operation decode
    always_comb begin
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        built_next  = built_reg;
        i_next      = i_reg;
        s_next      = s_reg;
        j_next      = j_reg;
        ii_next     = ii_reg;
        off_next    = off_reg;
        sum_next    = sum_reg;
        b_next      = b_reg;
        bidx_next   = bidx_reg;
        rs_next     = rs_reg;
        nrank_next  = nrank_reg;
        v_next      = v_reg;
        kv_next     = kv_reg;
        prev_next   = prev_reg;
        base_next   = base_reg;
        r_next      = r_reg;
        inrng_next  = inrng_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next = m_word_reg;

        txt_we = 1'b0; txt_wa = eff_cnt[AW-1:0]; txt_wd = s_data.data_byte;
        txt_ra = i_reg[AW-1:0];
        bkt_we = 1'b0; bkt_wa = b_reg; bkt_wd = '0; bkt_ra = bk;
        sa_we = 1'b0; sa_wa = j_reg[AW-1:0]; sa_wd = v_reg; sa_ra = j_reg[AW-1:0];
        rk_we = 1'b0; rk_wa = i_reg[AW-1:0]; rk_wd = AW'(bkt_rd); rk_ra = sa_rd;
        key_we = 1'b0; key_wa = j_reg[AW-1:0]; key_wd = kv_reg;
        key_ra = j_reg[AW-1:0];

        case (cmd.op)
            // Accept loads and reads
            sab_pkg::OP_IDLE: begin
                sa_ra = AW'(s_data.position);
                if (acc && is_load) begin
                    built_next = 1'b0;
                    if (built_reg) ovf_next = 1'b0;
                    if (32'(eff_cnt) < 32'(MAX_LEN)) begin
                        txt_we   = 1'b1;
                        cnt_next = CW'(eff_cnt + 1'b1);
                    end else begin
                        cnt_next = eff_cnt;
                        ovf_next = 1'b1;
                    end
                    if (s_data.last) begin
                        i_next   = '0;
                        b_next   = '0;
                        sum_next = '0;
                        off_next = OW'(1);
                    end
                end else if (acc) begin
                    if (!built_reg) begin
                        m_valid_next = 1'b1;
                        m_word_next  = '{suffix_start: '0,
                                         text_length: 11'(cnt_reg),
                                         status: sab_pkg::STAT_NOT_BUILT};
                    end else if (!pos_ok) begin
                        m_valid_next = 1'b1;
                        m_word_next  = '{suffix_start: '0,
                                         text_length: 11'(cnt_reg),
                                         status: sab_pkg::STAT_RANGE};
                    end
                end
            end
            sab_pkg::OP_RD_OUT: begin
                m_valid_next = 1'b1;
                m_word_next  = '{suffix_start: 10'(sa_rd),
                                 text_length: 11'(cnt_reg),
                                 status: sab_pkg::STAT_OK};
            end
            // Clear bucket counters
            sab_pkg::OP_CLR: begin
                bkt_we = 1'b1;
                b_next = stat.b_last ? '0 : BW'(b_reg + 1'b1);
            end
            // Count bytes per bucket
            sab_pkg::OP_CNT_RB: bidx_next = bk;
            sab_pkg::OP_CNT_WB: begin
                bkt_we = 1'b1;
                bkt_wa = bidx_reg;
                bkt_wd = CW'(bkt_rd + 1'b1);
                i_next = stat.i_last ? '0 : i_plus1;
            end
            // Bucket starts by prefix sum
            sab_pkg::OP_PFX_R: bkt_ra = b_reg;
            sab_pkg::OP_PFX_W: begin
                bkt_we   = 1'b1;
                bkt_wd   = sum_reg;
                sum_next = CW'(sum_reg + bkt_rd);
                b_next   = stat.b_last ? '0 : BW'(b_reg + 1'b1);
            end
            // Initial rank is the bucket start
            sab_pkg::OP_RNK_W: begin
                rk_we  = 1'b1;
                i_next = stat.i_last ? '0 : i_plus1;
            end
            // Place suffixes into buckets in load order
            sab_pkg::OP_PLC_RB: bidx_next = bk;
            sab_pkg::OP_PLC_W: begin
                sa_we  = 1'b1;
                sa_wa  = AW'(bkt_rd);
                sa_wd  = i_reg[AW-1:0];
                bkt_we = 1'b1;
                bkt_wa = bidx_reg;
                bkt_wd = CW'(bkt_rd + 1'b1);
                i_next = stat.i_last ? '0 : i_plus1;
            end
            // Start of a doubling pass
            sab_pkg::OP_PASS_START: begin
                s_next = '0;
                i_next = CW'(1);
                sa_ra  = '0;
            end
            sab_pkg::OP_PASS_R0W: rs_next = rk_rd;
            // Scan for runs of equal rank
            sab_pkg::OP_SCAN_RS: sa_ra = i_reg[AW-1:0];
            sab_pkg::OP_SCAN_CMP: begin
                nrank_next = rk_rd;
                if (stat.rank_eq) i_next = i_plus1;
            end
            // Gather sort keys of the run, rank+1 or zero past the end
            sab_pkg::OP_KEY_INIT: j_next = CW'(s_reg);
            sab_pkg::OP_KEY_RR: begin
                rk_ra      = AW'(shift_pos);
                inrng_next = (shift_pos < OW'(cnt_reg));
            end
            sab_pkg::OP_KEY_W: begin
                key_we = 1'b1;
                key_wd = inrng_reg ? CW'(CW'(rk_rd) + 1'b1) : '0;
                j_next = j_plus1;
            end
            // Stable insertion sort of the run by key
            sab_pkg::OP_INS_INIT: ii_next = CW'(CW'(s_reg) + 1'b1);
            sab_pkg::OP_INS_RV: begin
                sa_ra  = ii_reg[AW-1:0];
                key_ra = ii_reg[AW-1:0];
                j_next = ii_reg;
            end
            sab_pkg::OP_INS_LV: begin
                v_next  = sa_rd;
                kv_next = key_rd;
            end
            sab_pkg::OP_INS_RP: begin
                sa_ra  = AW'(j_reg - 1'b1);
                key_ra = AW'(j_reg - 1'b1);
            end
            sab_pkg::OP_INS_CMP: begin
                sa_we  = 1'b1;
                key_we = 1'b1;
                if (stat.key_gt) begin
                    sa_wd  = sa_rd;
                    key_wd = key_rd;
                    j_next = CW'(j_reg - 1'b1);
                end else begin
                    ii_next = CW'(ii_reg + 1'b1);
                end
            end
            sab_pkg::OP_INS_PUT: begin
                sa_we   = 1'b1;
                key_we  = 1'b1;
                ii_next = CW'(ii_reg + 1'b1);
            end
            // New ranks for the run
            sab_pkg::OP_BASE_RS: begin
                sa_ra  = s_reg;
                key_ra = s_reg;
            end
            sab_pkg::OP_BASE_RR: prev_next = key_rd;
            sab_pkg::OP_BASE_W: begin
                base_next = rk_rd;
                r_next    = rk_rd;
                j_next    = CW'(CW'(s_reg) + 1'b1);
            end
            sab_pkg::OP_ASN_W: begin
                rk_we = 1'b1;
                rk_wa = sa_rd;
                if (prev_reg < key_rd) begin
                    rk_wd  = AW'(base_reg + AW'(j_reg - CW'(s_reg)));
                    r_next = rk_wd;
                end else begin
                    rk_wd = r_reg;
                end
                prev_next = key_rd;
                j_next    = j_plus1;
            end
            // Next run
            sab_pkg::OP_RUN_END: begin
                s_next  = i_reg[AW-1:0];
                rs_next = nrank_reg;
                i_next  = i_plus1;
            end
            sab_pkg::OP_PASS_END: off_next = OW'(off_reg << 1);
            sab_pkg::OP_DONE: begin
                built_next   = 1'b1;
                m_valid_next = 1'b1;
                m_word_next  = '{suffix_start: '0,
                                 text_length: 11'(cnt_reg),
                                 status: ovf_reg ? sab_pkg::STAT_OVERFLOW
                                                 : sab_pkg::STAT_OK};
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            built_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            built_reg   <= built_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        s_reg      <= s_next;
        j_reg      <= j_next;
        ii_reg     <= ii_next;
        off_reg    <= off_next;
        sum_reg    <= sum_next;
        b_reg      <= b_next;
        bidx_reg   <= bidx_next;
        rs_reg     <= rs_next;
        nrank_reg  <= nrank_next;
        v_reg      <= v_next;
        kv_reg     <= kv_next;
        prev_reg   <= prev_next;
        base_reg   <= base_next;
        r_reg      <= r_next;
        inrng_reg  <= inrng_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

endmodule

### hdl/suffix_array_builder.sv
// Suffix array builder top level: sequencer plus datapath.
// Depends on sab_pkg, sab_ctrl, sab_datapath (and sab_ram below it).
//
// Bytes load one per cycle while the builder is idle, with no result; a
// load marked last starts a prefix-doubling build and its single result
// word (length and overflow status) appears when the build finishes. The
// build is run by one sequencer over single-port-read memories: a clear of
// the ALPHABET bucket counters, byte counting, a prefix sum for the bucket
// starts, initial ranking and placing, then per doubling pass a run scan
// over the sorted positions plus, per run, key gathering, an insertion
// sort and new ranks. The insertion sort and the memory read latency set
// the build time. A read that hits a built entry goes through the read-out
// state before its word is registered, and no new word is taken until the
// builder is idle again; other reads answer in the cycle after acceptance.
module suffix_array_builder #(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sab_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sab_pkg::out_word_t m_data
);

    sab_pkg::cmd_t     cmd;
    sab_pkg::dp_stat_t stat;

    sab_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .stat(stat), .cmd(cmd));

    sab_datapath #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));

endmodule
